### hw/rtl/smx_pkg.sv
// Shared constants, types and formats for the stick deadband / expo mapper.
`timescale 1ns / 1ps

package smx_pkg;

    // Output and fixed-point geometry
    localparam int OUT_BITS  = 10;
    localparam int FRAC_BITS = 15;

    // Field and register widths
    localparam int RAW_W     = 16;
    localparam int DB_W      = 10;
    localparam int EXPO_W    = 11;
    localparam int PCT_W     = 7;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT  = 2'd2;

    // Saturation limits and reset values
    localparam logic [DB_W-1:0]   DEADBAND_SAT  = 10'd1013;
    localparam logic [EXPO_W-1:0] EXPO_SAT      = 11'd1024;
    localparam logic [EXPO_W-1:0] EXPO_FULL     = 11'd1024;
    localparam logic [PCT_W-1:0]  PERCENT_SAT   = 7'd100;
    localparam logic [PCT_W-1:0]  PERCENT_RESET = 7'd100;
    localparam logic [9:0]        STICK_FULL    = 10'd512;

    // Stick magnitude, unsigned Q1.F, 0..ONE
    localparam int MQ_W = FRAC_BITS + 1;
    localparam logic [MQ_W-1:0]     Q_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};
    localparam logic [OUT_BITS-1:0] CENTRE  = {1'b1, {(OUT_BITS - 1){1'b0}}};

    // Throttle: floor(x / 100) by reciprocal, exact after one correction
    localparam int TP_W = OUT_BITS + PCT_W;
    localparam int KS   = TP_W + 7;
    localparam int K_W  = KS - 6;
    localparam logic [K_W-1:0]  DIV100_K = K_W'((64'd1 << KS) / 100);
    localparam logic [TP_W-1:0] DIV_BY   = TP_W'(100);

    // Compare width for raw against OUT_MAX
    localparam int CMP_W = (OUT_BITS > RAW_W - 1) ? OUT_BITS : RAW_W - 1;

    // Divider pipeline: two quotient bits per stage; surplus low bits dropped
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = (FRAC_BITS + 1) / 2;
    localparam int QB             = BITS_PER_STAGE * DIV_STAGES;

    localparam int BACK_STAGES = 6;
    localparam int LATENCY     = 1 + DIV_STAGES + BACK_STAGES;

    // Word carried through the divider stages
    typedef struct packed {
        logic              thr;
        logic              neg;
        logic              dz;     // inside deadband
        logic              qtop;   // full-scale magnitude, quotient is ONE
        logic [TP_W-1:0]   tprod;  // throttle r * percent
        logic [MQ_W-1:0]   dvs;    // ONE - deadband
        logic [FRAC_BITS-1:0] rem;
        logic [QB-1:0]     quo;
    } smx_div_t;

endpackage

### hw/rtl/stick_deadband_expo_mapper_core.sv
// Top level: stick deadband / expo and throttle channel mapper, fully pipelined.
// Result path: front register, then the two-bits-per-stage rescale divider, then the back-end
//   stages, whose last register strobes the result on done.
// Throughput: one word per cycle while busy is low, set by a fully pipelined datapath; the receiver cannot stall.
// Reset: asynchronous, active low; clears all valid bits and restores the registers
//   (deadband 0, expo 0, throttle 100 %); busy is high in reset and in the cycle after release.
`timescale 1ns / 1ps

module stick_deadband_expo_mapper_core
    import smx_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    // command side
    input  logic                    start,
    output logic                    busy,
    input  logic signed [RAW_W-1:0] axis_raw,
    input  logic                    thr_mode,
    input  logic                    reversed,
    // result side, one-cycle strobe
    output logic                    done,
    output logic [OUT_BITS-1:0]     channel_value
);

    // Configuration registers. Saturation of out-of-range values is applied
    // where each one is used, so the raw written value is kept here.
    logic [DB_W-1:0]   deadband_reg;
    logic [EXPO_W-1:0] expo_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic              busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= '0;
            expo_reg     <= '0;
            pct_reg      <= PERCENT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEADBAND: deadband_reg <= cfg_data[DB_W-1:0];
                CFG_EXPO:     expo_reg     <= cfg_data[EXPO_W-1:0];
                CFG_PERCENT:  pct_reg      <= cfg_data[PCT_W-1:0];
                default:      ;  // unmapped index: write dropped
            endcase
        end
    end

    // The datapath never stalls, so busy only covers reset and the cycle
    // after release.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    logic accept;
    assign accept = start && !busy_reg;

    // Front stage: clamps, deadband offset, throttle product.
    logic     v_front;
    smx_div_t w_front;

    smx_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .axis_raw      (axis_raw),
        .thr_mode      (thr_mode),
        .reversed      (reversed),
        .deadband_q10  (deadband_reg),
        .thr_scale_pct (pct_reg),
        .out_valid     (v_front),
        .out_word      (w_front)
    );

    // Rescale divider: (mag - d) * ONE / (ONE - d), two quotient bits a
    // stage. Any surplus low quotient bits are dropped in the back end.
    logic     v_div [DIV_STAGES+1];
    smx_div_t w_div [DIV_STAGES+1];

    assign v_div[0] = v_front;
    assign w_div[0] = w_front;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        smx_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_div[g]),
            .in_word   (w_div[g]),
            .out_valid (v_div[g+1]),
            .out_word  (w_div[g+1])
        );
    end

    // Back end: cube, expo blend, output map with rounding, throttle /100,
    // final path select. Its last register drives the result ports.
    smx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_div[DIV_STAGES]),
        .in_word   (w_div[DIV_STAGES]),
        .expo_q10  (expo_reg),
        .out_valid (done),
        .out_value (channel_value)
    );

endmodule

### hw/rtl/smx_front.sv
// Input stage: saturation, deadband set-up and throttle scaling product.
`timescale 1ns / 1ps

module smx_front
    import smx_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [RAW_W-1:0] axis_raw,
    input  logic                    thr_mode,
    input  logic                    reversed,
    input  logic [DB_W-1:0]         deadband_q10,
    input  logic [PCT_W-1:0]        thr_scale_pct,
    output logic                    out_valid,
    output smx_div_t                out_word
);

    logic                 valid_reg;
    smx_div_t             word_reg;
    smx_div_t             word_next;

    logic [PCT_W-1:0]     pct;
    logic [CMP_W-1:0]     raw_mag_c;
    logic [OUT_BITS-1:0]  thr_r;
    logic [RAW_W:0]       raw_ext;
    logic [RAW_W:0]       abs_v;
    logic [9:0]           mag_s;
    logic [MQ_W-1:0]      mq;
    logic [DB_W-1:0]      db;
    logic [MQ_W-1:0]      dqf;
    logic [MQ_W-1:0]      diff;

    always_comb
    begin
        // throttle
        pct       = (thr_scale_pct > PERCENT_SAT) ? PERCENT_SAT : thr_scale_pct;
        raw_mag_c = CMP_W'(axis_raw[RAW_W-2:0]);
        if (axis_raw[RAW_W-1])
        begin
            thr_r = '0;
        end
        else if (raw_mag_c > CMP_W'(OUT_MAX))
        begin
            thr_r = OUT_MAX;
        end
        else
        begin
            thr_r = OUT_BITS'(raw_mag_c);
        end
        if (reversed)
        begin
            thr_r = OUT_MAX - thr_r;
        end

        // stick magnitude, saturated to half-scale 512
        raw_ext = {axis_raw[RAW_W-1], axis_raw};
        abs_v   = axis_raw[RAW_W-1] ? (~raw_ext + 1'b1) : raw_ext;
        mag_s   = (abs_v > (RAW_W + 1)'(STICK_FULL)) ? STICK_FULL : abs_v[9:0];
        mq      = MQ_W'(mag_s) << (FRAC_BITS - 9);

        db   = (deadband_q10 > DEADBAND_SAT) ? DEADBAND_SAT : deadband_q10;
        dqf  = MQ_W'(db) << (FRAC_BITS - 10);
        diff = mq - dqf;

        word_next.thr   = thr_mode;
        word_next.neg   = axis_raw[RAW_W-1] ^ reversed;
        word_next.dz    = (mq < dqf);
        word_next.qtop  = (mag_s == STICK_FULL);
        word_next.tprod = TP_W'(thr_r) * TP_W'(pct);
        word_next.dvs   = Q_ONE - dqf;
        // below full scale diff < divisor, so the quotient top bit is zero
        word_next.rem   = (mag_s == STICK_FULL) ? '0 : diff[FRAC_BITS-1:0];
        word_next.quo   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### hw/rtl/smx_div_stage.sv
// One restoring-division stage of the deadband rescale, two quotient bits.
`timescale 1ns / 1ps

module smx_div_stage
    import smx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  smx_div_t in_word,
    output logic     out_valid,
    output smx_div_t out_word
);

    logic     valid_reg;
    smx_div_t word_reg;
    smx_div_t word_next;

    always_comb
    begin
        logic [MQ_W-1:0] t;
        word_next = in_word;
        for (int j = 0; j < BITS_PER_STAGE; j++)
        begin
            t = {word_next.rem, 1'b0};
            if (t >= word_next.dvs)
            begin
                word_next.rem = FRAC_BITS'(t - word_next.dvs);
                word_next.quo = {word_next.quo[QB-2:0], 1'b1};
            end
            else
            begin
                word_next.rem = t[FRAC_BITS-1:0];
                word_next.quo = {word_next.quo[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### hw/rtl/smx_back.sv
// Back end: cube, expo blend, output mapping and throttle divide by 100.
`timescale 1ns / 1ps

module smx_back
    import smx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  smx_div_t            in_word,
    input  logic [EXPO_W-1:0]   expo_q10,
    output logic                out_valid,
    output logic [OUT_BITS-1:0] out_value
);

    localparam int SQ_W  = 2 * MQ_W;
    localparam int TK_W  = TP_W + K_W;
    localparam int BL_W  = EXPO_W + MQ_W;
    localparam int S_W   = MQ_W + 1;
    localparam int SO_W  = S_W + OUT_BITS;

    logic [BACK_STAGES-1:0] v_reg;

    // stage 1
    logic [MQ_W-1:0]     m_next;
    logic [MQ_W-1:0]     m1_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [TK_W-1:0]     tk_reg;
    logic [TP_W-1:0]     tp1_reg;
    logic                thr1_reg;
    logic                neg1_reg;

    // stage 2
    logic [OUT_BITS-1:0] qe;
    logic [TP_W-1:0]     qrem;
    logic [OUT_BITS-1:0] thr_q_next;
    logic [MQ_W-1:0]     m2_reg;
    logic [SQ_W-1:0]     c1_reg;
    logic [OUT_BITS-1:0] thr_q2_reg;
    logic                thr2_reg;
    logic                neg2_reg;

    // stage 3
    logic [EXPO_W-1:0]   e_sat;
    logic [BL_W-1:0]     ec_reg;
    logic [BL_W-1:0]     lm_reg;
    logic [OUT_BITS-1:0] thr_q3_reg;
    logic                thr3_reg;
    logic                neg3_reg;

    // stage 4
    logic [BL_W:0]       blend_sum;
    logic [S_W-1:0]      b_full;
    logic [MQ_W-1:0]     b_sat;
    logic [S_W-1:0]      s_next;
    logic [S_W-1:0]      s_reg;
    logic [OUT_BITS-1:0] thr_q4_reg;
    logic                thr4_reg;

    // stage 5
    logic [SO_W-1:0]     so_reg;
    logic [OUT_BITS-1:0] thr_q5_reg;
    logic                thr5_reg;

    // stage 6
    logic [SO_W-1:0]     so_rnd;
    logic [OUT_BITS-1:0] out_next;
    logic [OUT_BITS-1:0] out_reg;

    always_comb
    begin
        // deadband forces zero, full scale forces ONE
        if (in_word.dz)
        begin
            m_next = '0;
        end
        else if (in_word.qtop)
        begin
            m_next = Q_ONE;
        end
        else
        begin
            m_next = MQ_W'(in_word.quo[QB-1 -: FRAC_BITS]);
        end

        // reciprocal estimate is exact or one short
        qe         = tk_reg[KS +: OUT_BITS];
        qrem       = tp1_reg - TP_W'(qe) * DIV_BY;
        thr_q_next = (qrem >= DIV_BY) ? (qe + 1'b1) : qe;

        e_sat = (expo_q10 > EXPO_SAT) ? EXPO_SAT : expo_q10;

        blend_sum = (BL_W + 1)'(ec_reg) + (BL_W + 1)'(lm_reg);
        b_full    = blend_sum[10 +: S_W];
        b_sat     = (b_full > S_W'(Q_ONE)) ? Q_ONE : b_full[MQ_W-1:0];
        s_next    = neg3_reg ? (S_W'(Q_ONE) - S_W'(b_sat)) : (S_W'(Q_ONE) + S_W'(b_sat));

        so_rnd   = so_reg + SO_W'(Q_ONE);
        out_next = thr5_reg ? thr_q5_reg : so_rnd[FRAC_BITS + 1 +: OUT_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[BACK_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg     <= m_next;
        sq_reg     <= m_next * m_next;
        tk_reg     <= TK_W'(in_word.tprod) * TK_W'(DIV100_K);
        tp1_reg    <= in_word.tprod;
        thr1_reg   <= in_word.thr;
        neg1_reg   <= in_word.neg;

        m2_reg     <= m1_reg;
        c1_reg     <= sq_reg[FRAC_BITS +: MQ_W] * m1_reg;
        thr_q2_reg <= thr_q_next;
        thr2_reg   <= thr1_reg;
        neg2_reg   <= neg1_reg;

        ec_reg     <= BL_W'(e_sat) * BL_W'(c1_reg[FRAC_BITS +: MQ_W]);
        lm_reg     <= BL_W'(EXPO_FULL - e_sat) * BL_W'(m2_reg);
        thr_q3_reg <= thr_q2_reg;
        thr3_reg   <= thr2_reg;
        neg3_reg   <= neg2_reg;

        s_reg      <= s_next;
        thr_q4_reg <= thr_q3_reg;
        thr4_reg   <= thr3_reg;

        so_reg     <= SO_W'(s_reg) * SO_W'(OUT_MAX);
        thr_q5_reg <= thr_q4_reg;
        thr5_reg   <= thr4_reg;

        out_reg    <= out_next;
    end

    assign out_valid = v_reg[BACK_STAGES-1];
    assign out_value = out_reg;

endmodule

### hw/rtl/smx_chk.sv
// Port-level checker for the mapper core, bound to the top level.
`timescale 1ns / 1ps

module smx_chk
    import smx_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic signed [RAW_W-1:0] axis_raw,
    input logic                    thr_mode,
    input logic                    reversed,
    input logic                    done,
    input logic [OUT_BITS-1:0]     channel_value
);

    // every accepted word gives a strobe a fixed latency later
    a_acc_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word produced no result");

    // no strobe without a word accepted a latency earlier
    a_done_has_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without accepted word");

    // stick at rest maps to the centre code
    a_stick_centre: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !thr_mode && axis_raw == 16'sd0)
        |-> ##LATENCY (done && channel_value == CENTRE))
        else $error("stick centre mismatch");

    // negative throttle, not reversed, gives zero
    a_thr_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && thr_mode && !reversed && axis_raw[RAW_W-1])
        |-> ##LATENCY (done && channel_value == '0))
        else $error("negative throttle not zero");

endmodule

bind stick_deadband_expo_mapper_core smx_chk u_smx_chk (.*);
